@@ hw/rtl/assert_macros.svh @@
// ---------------------------------------------------------------------------
// assert_macros.svh
// Shared assertion macros for the frame sender checkers.
// ---------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked assertion, off while reset is applied
`define ASSERT_CLK(label, prop, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) prop) else $error(msg);

// Condition that must never be seen outside reset
`define ASSERT_NEVER(label, cond, msg) \
	`ASSERT_CLK(label, !(cond), msg)

`endif

@@ hw/rtl/tdfs_pkg.sv @@
// ---------------------------------------------------------------------------
// tdfs_pkg
// Types and constants shared by the two-wire display frame sender.
// ---------------------------------------------------------------------------
package tdfs_pkg;

	localparam int QUEUE_DEPTH_DEF = 8;
	localparam int FRAME_BYTES_DEF = 7;
	localparam int MAX_BYTES       = 7;
	localparam int LEN_W           = 3;
	localparam int NACK_W          = 8;
	localparam int STEP_W          = 4;

	typedef enum logic [1:0] {
		FUNC_ENQ    = 2'd0,
		FUNC_TICK   = 2'd1,
		FUNC_CLEAR  = 2'd2,
		FUNC_STATUS = 2'd3
	} func_t;

	// Bus phase of the bit sequencer
	typedef enum logic [5:0] {
		PH_IDLE  = 6'b000001,
		PH_START = 6'b000010,
		PH_WRITE = 6'b000100,
		PH_ACK   = 6'b001000,
		PH_STOP  = 6'b010000,
		PH_DONE  = 6'b100000
	} phase_t;

	typedef struct packed {
		logic [1:0]       func;
		logic [LEN_W-1:0] frame_length;
		logic [7:0]       byte0;
		logic [7:0]       byte1;
		logic [7:0]       byte2;
		logic [7:0]       byte3;
		logic [7:0]       byte4;
		logic [7:0]       byte5;
		logic [7:0]       byte6;
		logic             dio_sense;
	} item_t;

	typedef struct packed {
		logic accepted;
		logic clk_level;
		logic dio_level;
		logic clock_pulsed;
		logic ack_ok;
		logic busy_res;
	} result_t;

	// Classified word handed from front to back
	typedef struct packed {
		func_t                  kind;
		logic                   len_zero;
		logic [LEN_W-1:0]       len;
		logic [MAX_BYTES*8-1:0] bytes;
		logic                   sense;
	} op_t;

	typedef struct packed {
		logic empty;
		logic full;
		logic empty_d;
	} ring_stat_t;

	typedef struct packed {
		logic pop;
		logic clk_level;
		logic dio_level;
		logic pulsed;
		logic idle_d;
		logic nack_zero_q;
		logic nack_zero_d;
	} seq_stat_t;

endpackage

@@ hw/rtl/tdfs_fifo2.sv @@
// ---------------------------------------------------------------------------
// tdfs_fifo2
// Two-entry register queue; push and pop may happen in the same cycle.
// ---------------------------------------------------------------------------
module tdfs_fifo2 #(
	parameter int WIDTH = 1
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             push,
	output logic             full,
	input  logic [WIDTH-1:0] wdata,
	input  logic             pop,
	output logic             empty,
	output logic [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] slot_q [2];
	logic             wr_ptr_q;
	logic             rd_ptr_q;
	logic [1:0]       cnt_q;
	logic             do_push;
	logic             do_pop;

	assign full    = (cnt_q == 2'd2);
	assign empty   = (cnt_q == 2'd0);
	assign do_push = push && !full;
	assign do_pop  = pop && !empty;
	assign rdata   = slot_q[rd_ptr_q];

	// Pointers and fill count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			cnt_q    <= 2'd0;
		end else begin
			if (do_push) wr_ptr_q <= !wr_ptr_q;
			if (do_pop) rd_ptr_q <= !rd_ptr_q;
			cnt_q <= cnt_q + 2'(do_push) - 2'(do_pop);
		end
	end

	// Storage
	always_ff @(posedge clk) begin
		if (do_push) slot_q[wr_ptr_q] <= wdata;
	end

endmodule

@@ hw/rtl/tdfs_front.sv @@
// ---------------------------------------------------------------------------
// tdfs_front
// Takes input words, classifies them and queues them for the back end.
// ---------------------------------------------------------------------------
module tdfs_front #(
	parameter int FRAME_BYTES = tdfs_pkg::FRAME_BYTES_DEF
) (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           push,
	output logic           full,
	input  tdfs_pkg::item_t item,
	input  logic           op_pop,
	output logic           op_valid,
	output tdfs_pkg::op_t  op
);

	import tdfs_pkg::*;

	op_t        cls;
	logic       op_empty;
	logic [$bits(op_t)-1:0] op_raw;

	// Decode function, check and clamp frame length, pack bytes
	always_comb begin
		cls.kind     = func_t'(item.func);
		cls.len_zero = (item.frame_length == '0);
		cls.len      = (item.frame_length > LEN_W'(FRAME_BYTES)) ?
			LEN_W'(FRAME_BYTES) : item.frame_length;
		cls.bytes    = {item.byte6, item.byte5, item.byte4, item.byte3,
			item.byte2, item.byte1, item.byte0};
		cls.sense    = item.dio_sense;
	end

	tdfs_fifo2 #(.WIDTH($bits(op_t))) u_opq (
		.clk   (clk),
		.arst_n(arst_n),
		.push  (push),
		.full  (full),
		.wdata (cls),
		.pop   (op_pop),
		.empty (op_empty),
		.rdata (op_raw)
	);

	assign op_valid = !op_empty;
	assign op       = op_t'(op_raw);

endmodule

@@ hw/rtl/tdfs_ring.sv @@
// ---------------------------------------------------------------------------
// tdfs_ring
// Frame ring: holds up to depth-1 frames, registered read at the tail.
// ---------------------------------------------------------------------------
module tdfs_ring #(
	parameter int QUEUE_DEPTH = tdfs_pkg::QUEUE_DEPTH_DEF,
	parameter int FRAME_BYTES = tdfs_pkg::FRAME_BYTES_DEF
) (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            wr_en,
	input  logic [tdfs_pkg::LEN_W-1:0]      wr_len,
	input  logic [FRAME_BYTES*8-1:0]        wr_bytes,
	input  logic                            pop,
	output tdfs_pkg::ring_stat_t            stat,
	output logic [tdfs_pkg::LEN_W-1:0]      rd_len,
	output logic [FRAME_BYTES*8-1:0]        rd_bytes
);

	import tdfs_pkg::*;

	localparam int PW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
	localparam int EW = FRAME_BYTES * 8 + LEN_W;

	logic [EW-1:0] mem_q [QUEUE_DEPTH];
	logic [EW-1:0] rd_q;
	logic [PW-1:0] head_q;
	logic [PW-1:0] tail_q;
	logic [PW-1:0] head_inc;
	logic [PW-1:0] tail_inc;
	logic [PW-1:0] head_d;
	logic [PW-1:0] tail_d;

	// Wrapping increments
	assign head_inc = (head_q == PW'(QUEUE_DEPTH - 1)) ? '0 : head_q + PW'(1);
	assign tail_inc = (tail_q == PW'(QUEUE_DEPTH - 1)) ? '0 : tail_q + PW'(1);
	assign head_d   = wr_en ? head_inc : head_q;
	assign tail_d   = pop ? tail_inc : tail_q;

	assign stat.empty   = (head_q == tail_q);
	assign stat.full    = (head_inc == tail_q);
	assign stat.empty_d = (head_d == tail_d);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			head_q <= '0;
			tail_q <= '0;
		end else begin
			head_q <= head_d;
			tail_q <= tail_d;
		end
	end

	// Frame storage; tail entry read every cycle
	always_ff @(posedge clk) begin
		if (wr_en) mem_q[head_q] <= {wr_len, wr_bytes};
		rd_q <= mem_q[tail_q];
	end

	assign rd_len   = rd_q[EW-1 -: LEN_W];
	assign rd_bytes = rd_q[FRAME_BYTES*8-1:0];

endmodule

@@ hw/rtl/tdfs_seq.sv @@
// ---------------------------------------------------------------------------
// tdfs_seq
// Bit-level bus sequencer: start, bytes LSB first, acknowledge, stop.
// ---------------------------------------------------------------------------
module tdfs_seq #(
	parameter int FRAME_BYTES = tdfs_pkg::FRAME_BYTES_DEF
) (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       tick,
	input  logic                       clear,
	input  logic                       sense,
	input  logic                       ring_empty,
	input  logic [tdfs_pkg::LEN_W-1:0] rd_len,
	input  logic [FRAME_BYTES*8-1:0]   rd_bytes,
	output tdfs_pkg::seq_stat_t        stat
);

	import tdfs_pkg::*;

	localparam int BIW = (FRAME_BYTES > 1) ? $clog2(FRAME_BYTES) : 1;

	phase_t                 phase_q, phase_d;
	logic [STEP_W-1:0]      step_q, step_d;
	logic [FRAME_BYTES*8-1:0] active_q;
	logic [LEN_W-1:0]       left_q, left_d;
	logic [BIW-1:0]         idx_q, idx_d;
	logic [NACK_W-1:0]      nack_q, nack_d;
	logic                   clk_q, clk_d;
	logic                   dio_q, dio_d;
	logic                   load_q;
	logic                   pop;
	logic                   pulsed;
	logic [FRAME_BYTES*8-1:0] sel;

	// Current byte, shifted to the bottom; the bit is picked from it in the write phase
	assign sel = active_q >> {idx_q, 3'b000};

	// Next-state logic of the bus phases
	always_comb begin
		phase_d = phase_q;
		step_d  = step_q;
		left_d  = left_q;
		idx_d   = idx_q;
		nack_d  = nack_q;
		clk_d   = clk_q;
		dio_d   = dio_q;
		pop     = 1'b0;
		pulsed  = 1'b0;
		if (clear) begin
			nack_d = '0;
		end
		if (tick) begin
			case (phase_q)
				PH_IDLE: begin
					if (!ring_empty) begin
						pop     = 1'b1;
						idx_d   = '0;
						step_d  = '0;
						phase_d = PH_START;
					end
				end
				PH_START: begin
					if (step_q == 4'd0) begin
						dio_d  = 1'b1;
						clk_d  = 1'b1;
						step_d = 4'd1;
					end else if (step_q == 4'd1) begin
						dio_d  = 1'b0;
						step_d = 4'd2;
					end else begin
						clk_d   = 1'b0;
						step_d  = 4'd0;
						phase_d = PH_WRITE;
					end
				end
				PH_WRITE: begin
					if (step_q < 4'd8) begin
						dio_d  = sel[step_q[2:0]];
						clk_d  = 1'b1;
						pulsed = 1'b1;
						step_d = step_q + 4'd1;
					end else if (step_q == 4'd8) begin
						clk_d  = 1'b0;
						dio_d  = 1'b1;
						step_d = 4'd9;
					end else begin
						clk_d   = 1'b1;
						step_d  = 4'd0;
						phase_d = PH_ACK;
					end
				end
				PH_ACK: begin
					if (step_q == 4'd0) begin
						if (sense && nack_q != {NACK_W{1'b1}}) nack_d = nack_q + NACK_W'(1);
						step_d = 4'd1;
					end else begin
						clk_d  = 1'b0;
						step_d = 4'd0;
						if (left_q > LEN_W'(1)) begin
							left_d  = left_q - LEN_W'(1);
							idx_d   = idx_q + BIW'(1);
							phase_d = PH_WRITE;
						end else begin
							phase_d = PH_STOP;
						end
					end
				end
				PH_STOP: begin
					if (step_q == 4'd0) begin
						clk_d  = 1'b0;
						step_d = 4'd1;
					end else if (step_q == 4'd1) begin
						dio_d  = 1'b0;
						step_d = 4'd2;
					end else if (step_q == 4'd2) begin
						clk_d  = 1'b1;
						step_d = 4'd3;
					end else begin
						dio_d   = 1'b1;
						step_d  = 4'd0;
						phase_d = PH_DONE;
					end
				end
				default: begin
					step_d  = 4'd0;
					phase_d = PH_IDLE;
				end
			endcase
		end
	end

	// State registers; a popped frame passes through the ring's read register, then loads into active_q and left_q
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q  <= PH_IDLE;
			step_q   <= '0;
			active_q <= '0;
			left_q   <= '0;
			idx_q    <= '0;
			nack_q   <= '0;
			clk_q    <= 1'b1;
			dio_q    <= 1'b1;
			load_q   <= 1'b0;
		end else begin
			phase_q <= phase_d;
			step_q  <= step_d;
			idx_q   <= idx_d;
			nack_q  <= nack_d;
			clk_q   <= clk_d;
			dio_q   <= dio_d;
			load_q  <= pop;
			if (load_q) begin
				active_q <= rd_bytes;
				left_q   <= rd_len;
			end else begin
				left_q <= left_d;
			end
		end
	end

	assign stat.pop         = pop;
	assign stat.clk_level   = clk_d;
	assign stat.dio_level   = dio_d;
	assign stat.pulsed      = pulsed;
	assign stat.idle_d      = (phase_d == PH_IDLE);
	assign stat.nack_zero_q = (nack_q == '0);
	assign stat.nack_zero_d = (nack_d == '0);

endmodule

@@ hw/rtl/two_wire_display_frame_sender.sv @@
// ---------------------------------------------------------------------------
// two_wire_display_frame_sender
// Queues display frames and clocks them out on a two-wire bus, one step
// per tick word, with acknowledge counting.
// ---------------------------------------------------------------------------
// Result path: an input word is held in the word queue and its result word
// in the result queue, both registered; a full result queue holds the word back.
// Throughput: the back end executes one word per cycle unless the result queue is full.
// Both queues are two entries deep, so either side can stall independently.
// Reset: queues, ring pointers, sequencer and NACK count clear at once;
// bus lines go high. Ring contents are not cleared.
module two_wire_display_frame_sender #(
	parameter int QUEUE_DEPTH = tdfs_pkg::QUEUE_DEPTH_DEF,
	parameter int FRAME_BYTES = tdfs_pkg::FRAME_BYTES_DEF
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              push,
	output logic              full,
	input  tdfs_pkg::item_t   item,
	output logic              empty,
	input  logic              pop,
	output tdfs_pkg::result_t result
);

	import tdfs_pkg::*;

	op_t        op;
	logic       op_valid;
	logic       res_full;
	logic       fire;
	logic       acc;
	ring_stat_t ring_stat;
	seq_stat_t  seq_stat;
	result_t    res;
	logic [LEN_W-1:0]         rd_len;
	logic [FRAME_BYTES*8-1:0] rd_bytes;
	logic [$bits(result_t)-1:0] res_raw;

	tdfs_front #(.FRAME_BYTES(FRAME_BYTES)) u_front (
		.clk     (clk),
		.arst_n  (arst_n),
		.push    (push),
		.full    (full),
		.item    (item),
		.op_pop  (fire),
		.op_valid(op_valid),
		.op      (op)
	);

	// Back end executes one word whenever a word waits and the result queue has room
	assign fire = op_valid && !res_full;
	assign acc  = fire && (op.kind == FUNC_ENQ) && !op.len_zero && !ring_stat.full;

	tdfs_ring #(.QUEUE_DEPTH(QUEUE_DEPTH), .FRAME_BYTES(FRAME_BYTES)) u_ring (
		.clk     (clk),
		.arst_n  (arst_n),
		.wr_en   (acc),
		.wr_len  (op.len),
		.wr_bytes(op.bytes[FRAME_BYTES*8-1:0]),
		.pop     (seq_stat.pop),
		.stat    (ring_stat),
		.rd_len  (rd_len),
		.rd_bytes(rd_bytes)
	);

	tdfs_seq #(.FRAME_BYTES(FRAME_BYTES)) u_seq (
		.clk       (clk),
		.arst_n    (arst_n),
		.tick      (fire && (op.kind == FUNC_TICK)),
		.clear     (fire && (op.kind == FUNC_CLEAR)),
		.sense     (op.sense),
		.ring_empty(ring_stat.empty),
		.rd_len    (rd_len),
		.rd_bytes  (rd_bytes),
		.stat      (seq_stat)
	);

	// Result word; a clear reports the NACK status from before the clear
	always_comb begin
		res.accepted     = acc;
		res.clk_level    = seq_stat.clk_level;
		res.dio_level    = seq_stat.dio_level;
		res.clock_pulsed = seq_stat.pulsed;
		res.ack_ok       = (op.kind == FUNC_CLEAR) ? seq_stat.nack_zero_q :
			seq_stat.nack_zero_d;
		res.busy_res     = !seq_stat.idle_d || !ring_stat.empty_d;
	end

	tdfs_fifo2 #(.WIDTH($bits(result_t))) u_resq (
		.clk   (clk),
		.arst_n(arst_n),
		.push  (fire),
		.full  (res_full),
		.wdata (res),
		.pop   (pop),
		.empty (empty),
		.rdata (res_raw)
	);

	assign result = result_t'(res_raw);

endmodule

@@ hw/rtl/tdfs_checker.sv @@
// ---------------------------------------------------------------------------
// tdfs_checker
// Port-level checks on the frame sender, bound to the top level.
// ---------------------------------------------------------------------------
`include "assert_macros.svh"

module tdfs_checker (
	input logic              clk,
	input logic              arst_n,
	input logic              empty,
	input logic              pop,
	input tdfs_pkg::result_t result
);

	// Waiting result word stays until taken
	`ASSERT_CLK(a_res_held, !empty && !pop |=> !empty, "result word dropped")
	`ASSERT_CLK(a_res_stable, !empty && !pop |=> $stable(result), "result word changed")
	// A data bit is clocked out with the clock line high, while busy
	`ASSERT_NEVER(a_pulse_clk, !empty && result.clock_pulsed && !(result.clk_level && result.busy_res), "bit pulse without busy clock high")
	// A stored frame leaves the block busy
	`ASSERT_NEVER(a_acc_busy, !empty && result.accepted && !result.busy_res, "accepted frame but not busy")

endmodule

bind two_wire_display_frame_sender tdfs_checker u_checker (.*);

@@ verif/bus_status_checker.sv @@
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// bus_status_checker
// Watches the item and result queues of the two-wire frame sender, keeps a
// cycle-free model of the frame ring, bit sequencer and NACK count, and
// compares every popped status word against the model's prediction.
// ---------------------------------------------------------------------------
module bus_status_checker
	import tdfs_pkg::*;
(
	input  logic    clk,
	input  logic    arst_n,
	input  logic    push,
	input  logic    full,
	input  item_t   item,
	input  logic    empty,
	input  logic    pop,
	input  result_t result,
	output int      errors,
	output int      pending
);

	localparam int RING = QUEUE_DEPTH_DEF;

	// Model state
	logic [55:0] ring_bytes [RING];
	logic [2:0]  ring_len [RING];
	int unsigned wr_ptr;
	int unsigned rd_ptr;
	phase_t      seq_phase;
	logic [3:0]  seq_step;
	logic [55:0] cur_frame;
	logic [2:0]  bytes_to_go;
	logic [2:0]  byte_sel;
	logic [7:0]  nacks;
	logic        scl;
	logic        sda;

	result_t status_queue [$];
	result_t want;
	int      mismatches;

	assign errors = mismatches;

	// Applies one word to the model and returns the status it reports
	function automatic result_t predict_status(input item_t w);
		result_t     r;
		logic        nack_free;
		logic [7:0]  cur;
		int unsigned nxt;
		r = '0;
		nack_free = 1'b1;
		case (func_t'(w.func))
			FUNC_ENQ: begin
				nxt = (wr_ptr + 1) % RING;
				if (w.frame_length != 0 && nxt != rd_ptr) begin
					ring_bytes[wr_ptr] = {w.byte6, w.byte5, w.byte4, w.byte3,
						w.byte2, w.byte1, w.byte0};
					// overlong frames clip to the frame size
					ring_len[wr_ptr] = (w.frame_length > FRAME_BYTES_DEF) ?
						3'(FRAME_BYTES_DEF) : w.frame_length;
					wr_ptr = nxt;
					r.accepted = 1'b1;
				end
				nack_free = (nacks == 0);
			end
			FUNC_TICK: begin
				case (seq_phase)
					PH_IDLE: begin
						if (wr_ptr != rd_ptr) begin
							cur_frame = ring_bytes[rd_ptr];
							bytes_to_go = ring_len[rd_ptr];
							byte_sel = '0;
							seq_step = '0;
							rd_ptr = (rd_ptr + 1) % RING;
							seq_phase = PH_START;
						end
					end
					PH_START: begin
						if (seq_step == 0) begin
							sda = 1'b1;
							scl = 1'b1;
							seq_step = 1;
						end else if (seq_step == 1) begin
							sda = 1'b0;
							seq_step = 2;
						end else begin
							scl = 1'b0;
							seq_step = 0;
							seq_phase = PH_WRITE;
						end
					end
					PH_WRITE: begin
						// data bits go out LSB first, one clock pulse each
						if (seq_step < 8) begin
							cur = cur_frame[byte_sel*8 +: 8];
							sda = cur[seq_step[2:0]];
							scl = 1'b1;
							r.clock_pulsed = 1'b1;
							seq_step = seq_step + 1;
						end else if (seq_step == 8) begin
							scl = 1'b0;
							sda = 1'b1;
							seq_step = 9;
						end else begin
							scl = 1'b1;
							seq_step = 0;
							seq_phase = PH_ACK;
						end
					end
					PH_ACK: begin
						if (seq_step == 0) begin
							if (w.dio_sense && nacks != 8'hFF)
								nacks = nacks + 1;
							seq_step = 1;
						end else begin
							scl = 1'b0;
							seq_step = 0;
							if (bytes_to_go > 1) begin
								bytes_to_go = bytes_to_go - 1;
								byte_sel = byte_sel + 1;
								seq_phase = PH_WRITE;
							end else begin
								seq_phase = PH_STOP;
							end
						end
					end
					PH_STOP: begin
						if (seq_step == 0) begin
							scl = 1'b0;
							seq_step = 1;
						end else if (seq_step == 1) begin
							sda = 1'b0;
							seq_step = 2;
						end else if (seq_step == 2) begin
							scl = 1'b1;
							seq_step = 3;
						end else begin
							sda = 1'b1;
							seq_step = 0;
							seq_phase = PH_DONE;
						end
					end
					default: begin
						seq_step = 0;
						seq_phase = PH_IDLE;
					end
				endcase
				nack_free = (nacks == 0);
			end
			FUNC_CLEAR: begin
				// status reports the count before the clear
				nack_free = (nacks == 0);
				nacks = '0;
			end
			default: begin
				nack_free = (nacks == 0);
			end
		endcase
		r.clk_level = scl;
		r.dio_level = sda;
		r.ack_ok = nack_free;
		r.busy_res = (seq_phase != PH_IDLE) || (wr_ptr != rd_ptr);
		return r;
	endfunction

	// Predict on accepted items, compare on accepted results
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr <= 0;
			rd_ptr <= 0;
			seq_phase <= PH_IDLE;
			seq_step <= '0;
			cur_frame <= '0;
			bytes_to_go <= '0;
			byte_sel <= '0;
			nacks <= '0;
			scl <= 1'b1;
			sda <= 1'b1;
			status_queue.delete();
			mismatches <= 0;
		end else begin
			if (push && !full)
				status_queue.push_back(predict_status(item));
			if (pop && !empty) begin
				if (status_queue.size() == 0) begin
					if (mismatches < 10)
						$display("%0t: unexpected status word %b", $realtime, result);
					mismatches = mismatches + 1;
				end else begin
					want = status_queue.pop_front();
					if (result.accepted !== want.accepted ||
						result.clk_level !== want.clk_level ||
						result.dio_level !== want.dio_level ||
						result.clock_pulsed !== want.clock_pulsed ||
						result.ack_ok !== want.ack_ok ||
						result.busy_res !== want.busy_res) begin
						// fields: acc clk dio pulse ack busy
						if (mismatches < 10)
							$display("%0t: status mismatch expected %b got %b",
								$realtime, want, result);
						mismatches = mismatches + 1;
					end
				end
			end
		end
		pending = status_queue.size();
	end

endmodule

@@ verif/tb.sv @@
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// tb
// Stimulus and verdict for the two-wire display frame sender: directed
// corner words, a run of frames NACKed on every byte, then random frame
// traffic with idling on both queue sides and one long result stall.
// ---------------------------------------------------------------------------
module tb;
	import tdfs_pkg::*;

	logic    clk;
	logic    arst_n;
	logic    push;
	logic    full;
	item_t   item;
	logic    empty;
	logic    pop;
	result_t result;
	int      errors;
	int      pending;

	int tx_idle_pct = 6;
	int rx_idle_pct = 73;
	int sent = 0;
	bit squeezed;

	two_wire_display_frame_sender dut (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (push),
		.full   (full),
		.item   (item),
		.empty  (empty),
		.pop    (pop),
		.result (result)
	);

	bus_status_checker checker_i (
		.clk     (clk),
		.arst_n  (arst_n),
		.push    (push),
		.full    (full),
		.item    (item),
		.empty   (empty),
		.pop     (pop),
		.result  (result),
		.errors  (errors),
		.pending (pending)
	);

	// Clock
	initial clk = 1'b0;
	always #2 clk = ~clk;

	// Hard stop
	initial begin
		#2_000_000;
		$display("*** FAILED ***");
		$finish;
	end

	function automatic item_t make_word(input func_t f, input logic [2:0] len,
		input logic [55:0] b, input logic sense);
		item_t w;
		w.func = f;
		w.frame_length = len;
		w.byte0 = b[7:0];
		w.byte1 = b[15:8];
		w.byte2 = b[23:16];
		w.byte3 = b[31:24];
		w.byte4 = b[39:32];
		w.byte5 = b[47:40];
		w.byte6 = b[55:48];
		w.dio_sense = sense;
		return w;
	endfunction

	function automatic logic [55:0] rand_bytes();
		logic [63:0] r;
		r = {$urandom(), $urandom()};
		return r[55:0];
	endfunction

	// Offers one word; returns at the falling edge after it was taken
	task automatic send_word(input item_t w);
		while ($urandom_range(0, 99) < tx_idle_pct) begin
			push <= 1'b0;
			@(negedge clk);
		end
		push <= 1'b1;
		item <= w;
		do @(posedge clk); while (full);
		sent++;
		@(negedge clk);
	endtask

	// Result side: random stalls, plus one long hold once idling stops
	initial begin
		pop = 1'b0;
		@(posedge arst_n);
		forever begin
			@(negedge clk);
			if (rx_idle_pct == 0 && !squeezed) begin
				squeezed = 1'b1;
				pop <= 1'b0;
				repeat (64) @(negedge clk);
			end
			pop <= ($urandom_range(0, 99) >= rx_idle_pct);
		end
	end

	// Stimulus
	initial begin
		int          r;
		int          n;
		logic [2:0]  len;
		push = 1'b0;
		item = '0;
		arst_n = 1'b0;
		repeat (11) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		// Directed: status, idle tick, clear, zero length, byte extremes, full ring
		send_word(make_word(FUNC_STATUS, 3'd5, rand_bytes(), 1'b1));
		send_word(make_word(FUNC_TICK, 3'd0, '1, 1'b1));
		send_word(make_word(FUNC_CLEAR, 3'd7, '0, 1'b0));
		send_word(make_word(FUNC_ENQ, 3'd0, '1, 1'b0));
		send_word(make_word(FUNC_ENQ, 3'd1, 56'hFF, 1'b0));
		send_word(make_word(FUNC_ENQ, 3'd7, '0, 1'b1));
		send_word(make_word(FUNC_ENQ, 3'd7, '1, 1'b0));
		repeat (5)
			send_word(make_word(FUNC_ENQ, 3'($urandom_range(1, 7)), rand_bytes(), 1'b0));
		send_word(make_word(FUNC_STATUS, 3'd0, '0, 1'b0));

		// Every acknowledge a NACK over several full-length frames
		repeat (4) begin
			send_word(make_word(FUNC_ENQ, 3'd7, rand_bytes(), 1'b1));
			repeat (93)
				send_word(make_word(FUNC_TICK, 3'($urandom), rand_bytes(), 1'b1));
		end
		send_word(make_word(FUNC_CLEAR, 3'd0, '0, 1'b1));
		send_word(make_word(FUNC_STATUS, 3'd0, '0, 1'b1));

		// Random frame traffic up to the word total
		while (sent < 1950) begin
			if (sent >= 1300) begin
				tx_idle_pct = 0;
				rx_idle_pct = 0;
			end else if (sent >= 650) begin
				tx_idle_pct = 73;
				rx_idle_pct = 6;
			end
			r = $urandom_range(0, 99);
			if (r < 12) begin
				// burst of frames, now and then enough to overflow the ring
				n = ($urandom_range(0, 19) == 0) ? 9 : $urandom_range(1, 3);
				repeat (n) begin
					len = ($urandom_range(0, 14) == 0) ? 3'd0 : 3'($urandom_range(1, 7));
					send_word(make_word(FUNC_ENQ, len, rand_bytes(), 1'($urandom)));
				end
			end else if (r < 16) begin
				send_word(make_word(FUNC_CLEAR, 3'($urandom), rand_bytes(), 1'($urandom)));
			end else if (r < 19) begin
				send_word(make_word(FUNC_STATUS, 3'($urandom), rand_bytes(), 1'($urandom)));
			end else begin
				repeat ($urandom_range(1, 60))
					send_word(make_word(FUNC_TICK, 3'($urandom), rand_bytes(), 1'($urandom)));
			end
		end
		push <= 1'b0;
		tx_idle_pct = 0;
		rx_idle_pct = 0;

		// Drain, then allow for the pipeline latency
		wait (pending == 0);
		repeat (20) @(posedge clk);
		if (errors == 0 && pending == 0)
			$display("*** PASSED ***");
		else
			$display("*** FAILED ***");
		$finish;
	end

endmodule
